// ===== design/iaf_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer formatter package
// Shared codes, character constants, state and status types for the
// integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package iaf_pkg;

	localparam logic [1:0] KIND_CHAR     = 2'd0;
	localparam logic [1:0] KIND_SIGNED   = 2'd1;
	localparam logic [1:0] KIND_UNSIGNED = 2'd2;
	localparam logic [1:0] KIND_POINTER  = 2'd3;

	localparam logic [1:0] RADIX_DEFAULT = 2'd0;
	localparam logic [1:0] RADIX_DEC     = 2'd1;
	localparam logic [1:0] RADIX_HEX     = 2'd2;

	localparam logic [1:0] FILL_NONE  = 2'd0;
	localparam logic [1:0] FILL_ZERO  = 2'd1;
	localparam logic [1:0] FILL_SPACE = 2'd2;

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// Largest digit count of a 32-bit value (decimal).
	localparam int unsigned NDIG   = 10;
	localparam int unsigned NDIG_W = $clog2(NDIG + 1);

	// Reciprocal of ten: floor(x / 10) == (x * RECIP10) >> 35 for any 32-bit x.
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_CHAR,
		ST_SIGN,
		ST_PFX0,
		ST_PFXX,
		ST_FILL,
		ST_DIGIT
	} iaf_state_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] digit;
		logic       last;
	} iaf_dig_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] d8;
		d8 = {4'b0, d};
		if (d8 < 8'd10) begin
			return d8 + CH_ZERO;
		end
		return d8 - 8'd10 + (upper ? CH_UPPER_A : CH_LOWER_A);
	endfunction

endpackage

// ===== design/iaf_in_if.sv =====
// ----------------------------------------------------------------------------
// Argument channel
// Carries one formatted argument per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface iaf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  arg_kind;
	logic [31:0] arg_value;
	logic [1:0]  radix_sel;
	logic        upper_case;
	logic        show_prefix;
	logic [1:0]  fill_mode;
	logic [5:0]  field_width;

	modport source (
		output valid, arg_kind, arg_value, radix_sel, upper_case, show_prefix,
			fill_mode, field_width,
		input ready
	);
	modport sink (
		input valid, arg_kind, arg_value, radix_sel, upper_case, show_prefix,
			fill_mode, field_width,
		output ready
	);
endinterface

// ===== design/iaf_out_if.sv =====
// ----------------------------------------------------------------------------
// Character channel
// Carries one ASCII character per item, with a marker on the final one.
// ----------------------------------------------------------------------------
interface iaf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (output valid, out_char, last_char, input ready);
	modport sink (input valid, out_char, last_char, output ready);
endinterface

// ===== design/iaf_digit_unit.sv =====
// ----------------------------------------------------------------------------
// Digit extraction unit
// Splits a 32-bit magnitude into digits, least significant first. A hex digit
// is the low nibble; a decimal digit takes a reciprocal multiply and then a
// remainder step.
// ----------------------------------------------------------------------------
module iaf_digit_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       value,
	input  logic              hex,
	output iaf_pkg::iaf_dig_t dig
);

	logic        busy_q;
	logic        phase_q;
	logic        hex_q;
	logic [31:0] mag_q;
	logic [28:0] quot_q;
	logic [63:0] prod;
	logic [31:0] q10;
	logic [31:0] rem;

	assign prod = 64'(mag_q) * 64'(iaf_pkg::RECIP10);
	assign q10  = {quot_q, 3'b0} + {2'b0, quot_q, 1'b0};
	assign rem  = mag_q - q10;

	always_comb begin
		dig.valid = busy_q && (hex_q || phase_q);
		dig.digit = hex_q ? mag_q[3:0] : rem[3:0];
		dig.last  = hex_q ? (mag_q[31:4] == 28'd0) : (quot_q == 29'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (busy_q) begin
			if (hex_q) begin
				busy_q <= !dig.last;
			end else if (phase_q) begin
				phase_q <= 1'b0;
				busy_q  <= !dig.last;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hex_q <= hex;
			mag_q <= value;
		end else if (busy_q) begin
			if (hex_q) begin
				mag_q <= {4'b0, mag_q[31:4]};
			end else if (phase_q) begin
				mag_q <= {3'b0, quot_q};
			end else begin
				quot_q <= prod[63:35];
			end
		end
	end

endmodule

// ===== design/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// Integer-to-ASCII formatter
// Turns one formatted argument into a stream of ASCII characters.
// ----------------------------------------------------------------------------
// The arg channel takes one argument per item: a char, signed, unsigned or
// pointer value with its radix, case, prefix, fill and width flags. The res
// channel returns the characters one item each, with last_char set on the
// final character of the argument.
// A char argument passes from the CHAR state into the output register. A
// number first runs through the digit unit, which serves both radixes: a hex
// digit is the low nibble, while a decimal digit takes a reciprocal multiply
// and then a remainder step. Characters then leave at one per cycle while the
// receiver keeps ready high: sign, prefix, fill and digits, up to 63 in all.
// The digit unit sets the conversion time, the output port the emission time.
// The block accepts a new argument once the final character of the previous
// one sits in the output register. When the receiver holds ready low, the
// output register and the emitting states simply wait; a conversion runs on.
// Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
	parameter int unsigned MAX_WIDTH = 60
) (
	input  logic      clk,
	input  logic      arst_n,
	iaf_in_if.sink    arg,
	iaf_out_if.source res
);

	iaf_pkg::iaf_state_t state_q, state_d;
	iaf_pkg::iaf_dig_t   dig;

	logic                      out_valid_q;
	logic [7:0]                out_char_q;
	logic                      out_last_q;
	logic                      ld_out;
	logic [7:0]                out_char_d;
	logic                      out_last_d;
	logic                      emit_ok;
	logic                      accept;
	logic                      conv_start;
	logic                      hex_sel;
	logic                      negative;
	logic [31:0]               magnitude;
	logic [5:0]                wsat;

	logic [7:0]                char_q;
	logic                      neg_q;
	logic                      pfx_q;
	logic                      upper_q;
	logic                      fill_en_q;
	logic [7:0]                fill_char_q;
	logic [5:0]                wsat_q;
	logic [5:0]                fill_cnt_q;
	logic [iaf_pkg::NDIG_W-1:0] nd_q;
	logic [iaf_pkg::NDIG_W-1:0] nd_next;
	logic [iaf_pkg::NDIG_W-1:0] rd_idx_q;
	logic [5:0]                fill_calc;
	logic [3:0]                dbuf_q [iaf_pkg::NDIG];

	assign emit_ok   = !out_valid_q || res.ready;
	assign arg.ready = (state_q == iaf_pkg::ST_IDLE);
	assign accept    = arg.valid && arg.ready;
	assign conv_start = accept && (arg.arg_kind != iaf_pkg::KIND_CHAR);

	assign hex_sel = (arg.radix_sel == iaf_pkg::RADIX_HEX) ||
		((arg.radix_sel != iaf_pkg::RADIX_DEC) && (arg.arg_kind == iaf_pkg::KIND_POINTER));
	assign negative  = (arg.arg_kind == iaf_pkg::KIND_SIGNED) && arg.arg_value[31];
	assign magnitude = negative ? (32'd0 - arg.arg_value) : arg.arg_value;
	assign wsat = (32'(arg.field_width) > MAX_WIDTH) ? 6'(MAX_WIDTH) : arg.field_width;

	assign nd_next   = nd_q + 1'b1;
	assign fill_calc = (fill_en_q && (wsat_q > 6'(nd_next))) ? (wsat_q - 6'(nd_next)) : 6'd0;

	assign res.valid     = out_valid_q;
	assign res.out_char  = out_char_q;
	assign res.last_char = out_last_q;

	iaf_digit_unit u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.value  (magnitude),
		.hex    (hex_sel),
		.dig    (dig)
	);

	always_comb begin
		state_d    = state_q;
		ld_out     = 1'b0;
		out_char_d = iaf_pkg::CH_ZERO;
		out_last_d = 1'b0;
		unique case (state_q)
			iaf_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (arg.arg_kind == iaf_pkg::KIND_CHAR) ?
						iaf_pkg::ST_CHAR : iaf_pkg::ST_CONV;
				end
			end
			iaf_pkg::ST_CONV: begin
				if (dig.valid && dig.last) begin
					priority if (neg_q) state_d = iaf_pkg::ST_SIGN;
					else if (pfx_q) state_d = iaf_pkg::ST_PFX0;
					else if (fill_calc != 6'd0) state_d = iaf_pkg::ST_FILL;
					else state_d = iaf_pkg::ST_DIGIT;
				end
			end
			iaf_pkg::ST_CHAR: begin
				if (emit_ok) begin
					ld_out     = 1'b1;
					out_char_d = char_q;
					out_last_d = 1'b1;
					state_d    = iaf_pkg::ST_IDLE;
				end
			end
			iaf_pkg::ST_SIGN: begin
				if (emit_ok) begin
					ld_out     = 1'b1;
					out_char_d = iaf_pkg::CH_MINUS;
					priority if (pfx_q) state_d = iaf_pkg::ST_PFX0;
					else if (fill_cnt_q != 6'd0) state_d = iaf_pkg::ST_FILL;
					else state_d = iaf_pkg::ST_DIGIT;
				end
			end
			iaf_pkg::ST_PFX0: begin
				if (emit_ok) begin
					ld_out     = 1'b1;
					out_char_d = iaf_pkg::CH_ZERO;
					state_d    = iaf_pkg::ST_PFXX;
				end
			end
			iaf_pkg::ST_PFXX: begin
				if (emit_ok) begin
					ld_out     = 1'b1;
					out_char_d = upper_q ? iaf_pkg::CH_UPPER_X : iaf_pkg::CH_LOWER_X;
					state_d    = (fill_cnt_q != 6'd0) ? iaf_pkg::ST_FILL : iaf_pkg::ST_DIGIT;
				end
			end
			iaf_pkg::ST_FILL: begin
				if (emit_ok) begin
					ld_out     = 1'b1;
					out_char_d = fill_char_q;
					if (fill_cnt_q == 6'd1) begin
						state_d = iaf_pkg::ST_DIGIT;
					end
				end
			end
			iaf_pkg::ST_DIGIT: begin
				if (emit_ok) begin
					ld_out     = 1'b1;
					out_char_d = iaf_pkg::digit_char(dbuf_q[rd_idx_q], upper_q);
					out_last_d = (rd_idx_q == '0);
					if (rd_idx_q == '0) begin
						state_d = iaf_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = iaf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iaf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			nd_q        <= '0;
			rd_idx_q    <= '0;
			fill_cnt_q  <= 6'd0;
		end else begin
			state_q <= state_d;
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				nd_q <= '0;
			end else if (state_q == iaf_pkg::ST_CONV && dig.valid) begin
				nd_q <= nd_next;
				if (dig.last) begin
					fill_cnt_q <= fill_calc;
					rd_idx_q   <= nd_q;
				end
			end else if (ld_out && state_q == iaf_pkg::ST_FILL) begin
				fill_cnt_q <= fill_cnt_q - 6'd1;
			end else if (ld_out && state_q == iaf_pkg::ST_DIGIT && rd_idx_q != '0) begin
				rd_idx_q <= rd_idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_char_q <= out_char_d;
			out_last_q <= out_last_d;
		end
		if (accept) begin
			char_q      <= arg.arg_value[7:0];
			neg_q       <= negative;
			pfx_q       <= arg.show_prefix && hex_sel;
			upper_q     <= arg.upper_case;
			fill_en_q   <= (arg.fill_mode == iaf_pkg::FILL_ZERO) ||
				(arg.fill_mode == iaf_pkg::FILL_SPACE);
			fill_char_q <= (arg.fill_mode == iaf_pkg::FILL_ZERO) ?
				iaf_pkg::CH_ZERO : iaf_pkg::CH_SPACE;
			wsat_q      <= wsat;
		end
		if (state_q == iaf_pkg::ST_CONV && dig.valid) begin
			dbuf_q[nd_q] <= dig.digit;
		end
	end

	a_dig_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> state_q == iaf_pkg::ST_CONV)
		else $error("Digit unit reported a digit outside conversion.");

	a_nd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == iaf_pkg::ST_CONV |-> nd_q < iaf_pkg::NDIG_W'(iaf_pkg::NDIG))
		else $error("Digit count exceeded the digit buffer.");

	a_rd_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == iaf_pkg::ST_DIGIT |-> rd_idx_q < nd_q)
		else $error("Digit read index beyond the converted digits.");

	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == iaf_pkg::ST_FILL |-> fill_cnt_q != 6'd0)
		else $error("Fill state entered with an empty fill count.");

endmodule

// ===== tb/integer_to_ascii_formatter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer-to-ASCII formatter testbench
// Sends formatted arguments through the arg channel, first from a table of
// edge cases and then at random. Expected characters come from the row text
// or are worked out for every accepted argument, and the res channel is
// compared against them in order. Both sides idle at random, and the receiver
// holds off once for a long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_test;

	localparam int unsigned MAX_WIDTH = 60;
	localparam logic [1:0] RADIX_UNUSED = 2'd3;
	localparam logic [1:0] FILL_UNUSED = 2'd3;
	localparam int RANDOM_ARGS = 437;
	localparam int HOLD_AT = 120;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES = 50;

	typedef struct packed {
		logic [1:0]  arg_kind;
		logic [31:0] arg_value;
		logic [1:0]  radix_sel;
		logic        upper_case;
		logic        show_prefix;
		logic [1:0]  fill_mode;
		logic [5:0]  field_width;
	} arg_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
	} char_item_t;

	logic clk;
	logic arst_n;

	iaf_in_if arg_ch ();
	iaf_out_if res_ch ();

	integer_to_ascii_formatter #(
		.MAX_WIDTH(MAX_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.arg(arg_ch),
		.res(res_ch)
	);

	char_item_t expected_chars[$];
	arg_item_t table_args[$];
	string table_text[$];
	int errors = 0;
	int args_sent = 0;
	int stalled_cycles = 0;
	bit sender_burst = 0;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		arg_ch.valid = 1'b0;
		arg_ch.arg_kind = iaf_pkg::KIND_CHAR;
		arg_ch.arg_value = '0;
		arg_ch.radix_sel = iaf_pkg::RADIX_DEFAULT;
		arg_ch.upper_case = 1'b0;
		arg_ch.show_prefix = 1'b0;
		arg_ch.fill_mode = iaf_pkg::FILL_NONE;
		arg_ch.field_width = '0;
		res_ch.ready = 1'b0;
	end

	always #10 clk = ~clk;

	task automatic queue_line(input logic [7:0] line[$]);
		char_item_t c;
		foreach (line[i]) begin
			c.out_char = line[i];
			c.last_char = (i == line.size() - 1);
			expected_chars.push_back(c);
		end
	endtask

	task automatic queue_text(input string text);
		logic [7:0] line[$];
		for (int i = 0; i < text.len(); i++) begin
			line.push_back(text[i]);
		end
		queue_line(line);
	endtask

	task automatic queue_formatted(input arg_item_t a);
		logic [7:0] line[$];
		logic [7:0] digits[$];
		logic [31:0] mag;
		logic [31:0] d;
		int unsigned radix;
		int unsigned width;
		logic negative;
		if (a.arg_kind == iaf_pkg::KIND_CHAR) begin
			line.push_back(a.arg_value[7:0]);
			queue_line(line);
			return;
		end
		if (a.radix_sel == iaf_pkg::RADIX_DEC) begin
			radix = 10;
		end else if (a.radix_sel == iaf_pkg::RADIX_HEX) begin
			radix = 16;
		end else begin
			radix = (a.arg_kind == iaf_pkg::KIND_POINTER) ? 16 : 10;
		end
		negative = (a.arg_kind == iaf_pkg::KIND_SIGNED) && a.arg_value[31];
		mag = negative ? 32'd0 - a.arg_value : a.arg_value;
		do begin
			d = mag % radix;
			if (d < 10) begin
				digits.push_front(iaf_pkg::CH_ZERO + d[7:0]);
			end else begin
				digits.push_front((a.upper_case ? iaf_pkg::CH_UPPER_A : iaf_pkg::CH_LOWER_A) +
					d[7:0] - 8'd10);
			end
			mag = mag / radix;
		end while (mag != 0);
		if (negative) begin
			line.push_back(iaf_pkg::CH_MINUS);
		end
		if (a.show_prefix && radix == 16) begin
			line.push_back(iaf_pkg::CH_ZERO);
			line.push_back(a.upper_case ? iaf_pkg::CH_UPPER_X : iaf_pkg::CH_LOWER_X);
		end
		width = (a.field_width > MAX_WIDTH) ? MAX_WIDTH : a.field_width;
		if ((a.fill_mode == iaf_pkg::FILL_ZERO || a.fill_mode == iaf_pkg::FILL_SPACE) &&
				width > digits.size()) begin
			repeat (width - digits.size()) begin
				line.push_back((a.fill_mode == iaf_pkg::FILL_ZERO) ?
					iaf_pkg::CH_ZERO : iaf_pkg::CH_SPACE);
			end
		end
		foreach (digits[i]) begin
			line.push_back(digits[i]);
		end
		queue_line(line);
	endtask

	task automatic send_argument(input arg_item_t a, input string text);
		int gap;
		arg_ch.valid <= 1'b1;
		arg_ch.arg_kind <= a.arg_kind;
		arg_ch.arg_value <= a.arg_value;
		arg_ch.radix_sel <= a.radix_sel;
		arg_ch.upper_case <= a.upper_case;
		arg_ch.show_prefix <= a.show_prefix;
		arg_ch.fill_mode <= a.fill_mode;
		arg_ch.field_width <= a.field_width;
		@(posedge clk);
		while (!arg_ch.ready) begin
			@(posedge clk);
		end
		args_sent++;
		if (text.len() != 0) begin
			queue_text(text);
		end else begin
			queue_formatted(a);
		end
		if ($urandom_range(0, 49) == 0) begin
			sender_burst = !sender_burst;
		end
		gap = $urandom_range(0, 19);
		if (sender_burst || gap < 10) begin
			gap = 0;
		end else if (gap < 18) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(5, 30);
		end
		if (gap > 0) begin
			arg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic add_row(input logic [1:0] kind, input logic [31:0] value,
			input logic [1:0] radix, input logic upper, input logic prefix,
			input logic [1:0] fill, input logic [5:0] width, input string text);
		arg_item_t a;
		a = '{kind, value, radix, upper, prefix, fill, width};
		table_args.push_back(a);
		table_text.push_back(text);
	endtask

	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 20);
			2: return 32'hFFFF_FFFF - $urandom_range(0, 20);
			3: return 32'h8000_0000 + $urandom_range(0, 20) - 32'd10;
			4: return $urandom_range(0, 255);
			default: return 32'd1 << $urandom_range(0, 31);
		endcase
	endfunction

	function automatic arg_item_t random_arg();
		arg_item_t a;
		a.arg_kind = 2'($urandom_range(0, 3));
		a.arg_value = random_value();
		a.radix_sel = 2'($urandom_range(0, 3));
		a.upper_case = 1'($urandom_range(0, 1));
		a.show_prefix = 1'($urandom_range(0, 1));
		a.fill_mode = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0) begin
			a.field_width = 6'($urandom_range(0, 63));
		end else begin
			a.field_width = 6'($urandom_range(0, 12));
		end
		return a;
	endfunction

	initial begin
		// Rows with an empty string are checked against the predictor.
		add_row(iaf_pkg::KIND_CHAR, 32'h0000_0041, iaf_pkg::RADIX_DEFAULT, 0, 0,
			iaf_pkg::FILL_NONE, 0, "A");
		add_row(iaf_pkg::KIND_CHAR, 32'hFFFF_FF00, iaf_pkg::RADIX_HEX, 1, 1,
			iaf_pkg::FILL_ZERO, 20, "");
		add_row(iaf_pkg::KIND_CHAR, 32'h0000_00FF, RADIX_UNUSED, 1, 1,
			FILL_UNUSED, 63, "");
		add_row(iaf_pkg::KIND_SIGNED, 32'h0000_0000, iaf_pkg::RADIX_DEFAULT, 0, 0,
			iaf_pkg::FILL_NONE, 0, "0");
		add_row(iaf_pkg::KIND_SIGNED, 32'h8000_0000, iaf_pkg::RADIX_DEFAULT, 0, 0,
			iaf_pkg::FILL_NONE, 0, "-2147483648");
		add_row(iaf_pkg::KIND_SIGNED, 32'hFFFF_FFFF, iaf_pkg::RADIX_DEC, 0, 1,
			iaf_pkg::FILL_NONE, 0, "-1");
		add_row(iaf_pkg::KIND_SIGNED, 32'h7FFF_FFFF, iaf_pkg::RADIX_DEFAULT, 0, 0,
			iaf_pkg::FILL_NONE, 0, "2147483647");
		add_row(iaf_pkg::KIND_UNSIGNED, 32'hFFFF_FFFF, iaf_pkg::RADIX_DEFAULT, 0, 0,
			iaf_pkg::FILL_NONE, 0, "4294967295");
		add_row(iaf_pkg::KIND_UNSIGNED, 32'hFFFF_FFFF, iaf_pkg::RADIX_HEX, 1, 1,
			iaf_pkg::FILL_NONE, 0, "0XFFFFFFFF");
		add_row(iaf_pkg::KIND_POINTER, 32'hDEAD_BEEF, iaf_pkg::RADIX_DEFAULT, 0, 1,
			iaf_pkg::FILL_NONE, 0, "0xdeadbeef");
		add_row(iaf_pkg::KIND_UNSIGNED, 32'h0000_00FF, iaf_pkg::RADIX_DEC, 0, 1,
			iaf_pkg::FILL_NONE, 0, "255");
		add_row(iaf_pkg::KIND_POINTER, 32'h0000_00AB, RADIX_UNUSED, 0, 0,
			iaf_pkg::FILL_NONE, 0, "ab");
		add_row(iaf_pkg::KIND_UNSIGNED, 32'h0000_0005, iaf_pkg::RADIX_DEFAULT, 0, 0,
			FILL_UNUSED, 10, "5");
		add_row(iaf_pkg::KIND_UNSIGNED, 32'h0000_001F, iaf_pkg::RADIX_HEX, 0, 0,
			iaf_pkg::FILL_ZERO, 8, "0000001f");
		add_row(iaf_pkg::KIND_SIGNED, 32'hFFFF_FFD6, iaf_pkg::RADIX_DEFAULT, 0, 0,
			iaf_pkg::FILL_SPACE, 5, "-   42");
		add_row(iaf_pkg::KIND_UNSIGNED, 32'h0000_0000, iaf_pkg::RADIX_DEFAULT, 0, 0,
			iaf_pkg::FILL_ZERO, 63, "");
		add_row(iaf_pkg::KIND_POINTER, 32'hFFFF_FFFF, iaf_pkg::RADIX_DEFAULT, 1, 1,
			iaf_pkg::FILL_SPACE, 60, "");
		add_row(iaf_pkg::KIND_SIGNED, 32'hFFFF_FFFF, iaf_pkg::RADIX_HEX, 0, 1,
			iaf_pkg::FILL_ZERO, 61, "");
		add_row(iaf_pkg::KIND_UNSIGNED, 32'h0000_007B, iaf_pkg::RADIX_DEC, 0, 0,
			iaf_pkg::FILL_ZERO, 0, "123");
		add_row(iaf_pkg::KIND_SIGNED, 32'h8000_0000, iaf_pkg::RADIX_HEX, 0, 1,
			iaf_pkg::FILL_NONE, 0, "-0x80000000");
		add_row(iaf_pkg::KIND_UNSIGNED, 32'h0000_0000, iaf_pkg::RADIX_HEX, 0, 1,
			iaf_pkg::FILL_NONE, 0, "0x0");
		add_row(iaf_pkg::KIND_UNSIGNED, 32'h0000_0000, iaf_pkg::RADIX_DEFAULT, 0, 0,
			iaf_pkg::FILL_ZERO, 1, "0");
		add_row(iaf_pkg::KIND_UNSIGNED, 32'hFFFF_FFFF, iaf_pkg::RADIX_DEFAULT, 0, 0,
			iaf_pkg::FILL_ZERO, 10, "4294967295");
		add_row(iaf_pkg::KIND_SIGNED, 32'h0000_000A, iaf_pkg::RADIX_HEX, 1, 0,
			iaf_pkg::FILL_NONE, 0, "A");
		add_row(iaf_pkg::KIND_SIGNED, 32'h8000_0001, iaf_pkg::RADIX_HEX, 1, 1,
			iaf_pkg::FILL_SPACE, 40, "");

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_args[i]) begin
			send_argument(table_args[i], table_text[i]);
		end
		repeat (RANDOM_ARGS) begin
			send_argument(random_arg(), "");
		end
		arg_ch.valid <= 1'b0;
		wait (expected_chars.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		bit steady;
		bit held;
		steady = 0;
		held = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && args_sent >= HOLD_AT) begin
				held = 1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!steady && $urandom_range(0, 59) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(5, 30)) @(posedge clk);
			end else begin
				res_ch.ready <= steady || ($urandom_range(0, 3) != 0);
				@(posedge clk);
			end
			if ($urandom_range(0, 199) == 0) begin
				steady = !steady;
			end
		end
	end

	always @(posedge clk) begin
		char_item_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected character, actual char %h last %b", $time,
					res_ch.out_char, res_ch.last_char);
				errors++;
			end else begin
				e = expected_chars.pop_front();
				if (res_ch.out_char !== e.out_char) begin
					$display("%0t: out_char mismatch, expected %h actual %h", $time,
						e.out_char, res_ch.out_char);
					errors++;
				end
				if (res_ch.last_char !== e.last_char) begin
					$display("%0t: last_char mismatch, expected %b actual %b", $time,
						e.last_char, res_ch.last_char);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((arg_ch.valid && arg_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
		if (stalled_cycles == WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule
